[src/packed_three_bit_field_store_defines.svh]
// assertion macros for the packed three-bit field store
// no dependencies; included by the top level only
`ifndef PACKED_THREE_BIT_FIELD_STORE_DEFINES_SVH
`define PACKED_THREE_BIT_FIELD_STORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pfs_pkg.sv]
// shared constants and types for the packed three-bit field store
// no dependencies; imported by every module and interface
package pfs_pkg;

  localparam int STORE_BYTES  = 512;
  localparam int BYTE_BITS    = 8;
  localparam int ENTRY_W      = 3;
  localparam int POS_W        = 11;
  localparam int CFG_W        = 10;
  localparam int BIT_W        = 13;
  localparam int IDX_W        = BIT_W - 3;
  localparam int ENTRIES      = (STORE_BYTES * BYTE_BITS + ENTRY_W - 1) / ENTRY_W;
  localparam int ROW_LANES    = 8;
  localparam int LANE_W       = 3;
  localparam int ROWS         = (ENTRIES + ROW_LANES - 1) / ROW_LANES;
  localparam int ROW_IDX_W    = POS_W - LANE_W;
  localparam int ROW_BITS     = ROW_LANES * ENTRY_W;
  localparam int LAST_SINGLE_OFFSET = 5;

  localparam logic [0:0] REQ_READ  = 1'b0;
  localparam logic [0:0] REQ_WRITE = 1'b1;

  // one decoded access, decode -> store
  typedef struct packed {
    logic                 wr;
    logic                 oor;
    logic [ROW_IDX_W-1:0] row;
    logic [LANE_W-1:0]    lane;
    logic [ENTRY_W-1:0]   mask;
    logic [ENTRY_W-1:0]   wdata;
  } pfs_acc_t;

endpackage

[src/pfs_req_if.sv]
// request channel: valid/ready handshake with one access request
// depends on pfs_pkg
interface pfs_req_if;
  import pfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [0:0]         req_type;
  logic [POS_W-1:0]   position;
  logic [ENTRY_W-1:0] write_value;

  modport source (output valid, req_type, position, write_value, input ready);
  modport sink   (input valid, req_type, position, write_value, output ready);
endinterface

[src/pfs_rsp_if.sv]
// response channel: valid/ready handshake with one access result
// depends on pfs_pkg
interface pfs_rsp_if;
  import pfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] read_value;
  logic               out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

[src/pfs_decode.sv]
// turns a request into row, lane, bit mask and range flag
// depends on pfs_pkg
module pfs_decode (
  input  logic                          req_type,
  input  logic [pfs_pkg::POS_W-1:0]     position,
  input  logic [pfs_pkg::ENTRY_W-1:0]   write_value,
  input  logic [pfs_pkg::CFG_W-1:0]     bytes_in_use,
  output pfs_pkg::pfs_acc_t             acc
);
  import pfs_pkg::*;

  logic [BIT_W-1:0] bit_pos;
  logic [IDX_W-1:0] idx;
  logic [2:0]       off;
  logic [CFG_W-1:0] lim;
  logic             second_ok;

  // 3 * position as shift and add
  assign bit_pos = {1'b0, position, 1'b0} + {2'b0, position};
  assign idx     = bit_pos[BIT_W-1:3];
  assign off     = bit_pos[2:0];

  assign lim = (bytes_in_use > CFG_W'(STORE_BYTES)) ? CFG_W'(STORE_BYTES) : bytes_in_use;
  assign second_ok = ({1'b0, idx} + 11'd1) < {1'b0, lim};

  always_comb begin
    acc.wr    = (req_type == REQ_WRITE);
    acc.oor   = (idx >= lim);
    acc.row   = position[POS_W-1:LANE_W];
    acc.lane  = position[LANE_W-1:0];
    acc.wdata = write_value;
    // entries that start in the top two bits of a byte lose their high bits
    // when the following byte is past the limit
    if (off <= 3'(LAST_SINGLE_OFFSET) || second_ok) begin
      acc.mask = 3'b111;
    end else if (off == 3'd6) begin
      acc.mask = 3'b011;
    end else begin
      acc.mask = 3'b001;
    end
  end

endmodule

[src/pfs_store.sv]
// entry memory: rows of eight 3-bit entries with bit write enables
// depends on pfs_pkg; one valid bit per row stands in for the reset clear
module pfs_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  pfs_pkg::pfs_acc_t             acc,
  output logic [pfs_pkg::ENTRY_W-1:0]   rd_entry
);
  import pfs_pkg::*;

  logic [ROW_BITS-1:0] mem_r [ROWS];
  logic [ROWS-1:0]     row_vld_r;
  logic [ROW_BITS-1:0] rd_row_r;
  logic [LANE_W-1:0]   rd_lane_r;
  logic                rd_vld_r;

  logic [4:0]          sh;
  logic [ROW_BITS-1:0] bit_en;
  logic [ROW_BITS-1:0] bit_dat;

  assign sh      = {1'b0, acc.lane, 1'b0} + {2'b0, acc.lane};
  assign bit_dat = ROW_BITS'(acc.wdata & acc.mask) << sh;
  // first write to a row lays down zeros in the other lanes
  assign bit_en  = row_vld_r[acc.row] ? (ROW_BITS'(acc.mask) << sh) : {ROW_BITS{1'b1}};

  always_ff @(posedge clk) begin
    if (en && acc.wr) begin
      for (int i = 0; i < ROW_BITS; i++) begin
        if (bit_en[i]) begin
          mem_r[acc.row][i] <= bit_dat[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && !acc.wr) begin
      rd_row_r  <= mem_r[acc.row];
      rd_lane_r <= acc.lane;
      rd_vld_r  <= row_vld_r[acc.row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (en && acc.wr) begin
      row_vld_r[acc.row] <= 1'b1;
    end
  end

  assign rd_entry = rd_vld_r ? rd_row_r[ENTRY_W*rd_lane_r +: ENTRY_W] : '0;

endmodule

[src/packed_three_bit_field_store.sv]
// Packed three-bit field store. Takes one read or write request per clock
// unless out_ch.ready holds a result back, and returns one result per
// request, in order. The request register feeds the single access to the
// entry memory, which is registered at the same edge as the result register.
// The entry memory (171 rows of eight entries) takes one access per cycle,
// which sets the rate at one item per cycle while the output does not stall;
// a read sees every earlier write. The store reads as zero after reset with
// no clearing pass: a valid bit per row covers it. The user writes
// bytes_in_use through cfg_we / cfg_wdata only while the block is idle; the
// block does not enforce this. bytes_in_use resets to 512.
// depends on pfs_pkg, pfs_req_if, pfs_rsp_if, pfs_decode, pfs_store
`include "packed_three_bit_field_store_defines.svh"

module packed_three_bit_field_store (
  input  logic                       clk,
  input  logic                       rst_n,
  pfs_req_if.sink                    in_ch,
  pfs_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pfs_pkg::CFG_W-1:0]  cfg_wdata
);
  import pfs_pkg::*;

  logic [CFG_W-1:0]   bytes_in_use_r;

  // request stage
  logic               s1_v_r;
  logic [0:0]         s1_type_r;
  logic [POS_W-1:0]   s1_pos_r;
  logic [ENTRY_W-1:0] s1_val_r;

  // result stage
  logic               s2_v_r;
  logic               s2_wr_r;
  logic               s2_oor_r;
  logic [ENTRY_W-1:0] s2_mask_r;

  pfs_acc_t           acc;
  logic               adv;
  logic [ENTRY_W-1:0] rd_entry;

  assign adv         = s1_v_r && (!s2_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= CFG_W'(STORE_BYTES);
    end else if (cfg_we) begin
      bytes_in_use_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        s2_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_type_r <= in_ch.req_type;
      s1_pos_r  <= in_ch.position;
      s1_val_r  <= in_ch.write_value;
    end
    if (adv) begin
      s2_wr_r   <= acc.wr;
      s2_oor_r  <= acc.oor;
      s2_mask_r <= acc.mask;
    end
  end

  pfs_decode u_decode (
    .req_type     (s1_type_r),
    .position     (s1_pos_r),
    .write_value  (s1_val_r),
    .bytes_in_use (bytes_in_use_r),
    .acc          (acc)
  );

  // out-of-range requests never touch the memory
  pfs_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv && !acc.oor),
    .acc      (acc),
    .rd_entry (rd_entry)
  );

  assign out_ch.valid        = s2_v_r;
  assign out_ch.out_of_range = s2_oor_r;
  assign out_ch.read_value   = (s2_wr_r || s2_oor_r) ? '0 : (rd_entry & s2_mask_r);

  `PFS_ASSERT_NOW(a_oor_reads_zero, clk, rst_n, out_ch.valid && out_ch.out_of_range,
    out_ch.read_value == '0, "out of range result carries a nonzero value")
  `PFS_ASSERT_NOW(a_write_reads_zero, clk, rst_n, s2_v_r && s2_wr_r,
    out_ch.read_value == '0, "write result carries a nonzero value")
  `PFS_ASSERT_NEXT(a_held_request, clk, rst_n, s1_v_r && !adv,
    s1_v_r && $stable(s1_pos_r) && $stable(s1_type_r), "stalled request lost or changed")

endmodule

[tb/tb_top.sv]
// self-checking bench for packed_three_bit_field_store: reads and writes of 3-bit entries
// under several byte limits, checked against a shadow byte store kept in the bench
// depends on pfs_pkg, pfs_req_if, pfs_rsp_if and the block itself
module tb_top;
  import pfs_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_PER_PHASE = 45;
  localparam int MAX_POS          = (1 << POS_W) - 1;
  localparam int MAX_VAL          = (1 << ENTRY_W) - 1;

  typedef struct packed {
    logic [0:0]         kind;
    logic [POS_W-1:0]   pos;
    logic [ENTRY_W-1:0] val;
  } store_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] rd;
    logic               oor;
  } store_rsp_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_STALLS} rdy_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pfs_req_if in_ch ();
  pfs_rsp_if out_ch ();

  packed_three_bit_field_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block's store and limit register
  logic [7:0]       shadow_bytes [STORE_BYTES] = '{default: 8'h00};
  logic [CFG_W-1:0] shadow_bytes_in_use;

  store_req_t pending_reqs [$];
  store_rsp_t expected_rsps [$];

  int err_count   = 0;
  int idle_cycles = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_oor       = 0;
  int n_span      = 0;
  int n_cut       = 0;
  int n_results   = 0;
  int n_settings  = 1;
  int gap_left    = 0;
  int burst_left  = 1;

  rdy_mode_t ready_mode = RDY_ALWAYS;
  int        pattern_left = 0;
  int        stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int usable_bytes(input logic [CFG_W-1:0] cfg);
    return (cfg > STORE_BYTES) ? STORE_BYTES : int'(cfg);
  endfunction

  // last entry whose start byte is below the limit
  function automatic int last_entry_in(input int lim);
    int p;
    if (lim == 0) return 0;
    p = (BYTE_BITS * lim - 1) / ENTRY_W;
    return (p > MAX_POS) ? MAX_POS : p;
  endfunction

  function automatic store_rsp_t predict_store_access(input store_req_t req);
    int          bitpos;
    int          idx;
    int          off;
    int          lim;
    logic        second_ok;
    logic [15:0] window;
    logic [15:0] mask;
    store_rsp_t  rsp;
    rsp    = '0;
    bitpos = int'(req.pos) * ENTRY_W;
    idx    = bitpos / BYTE_BITS;
    off    = bitpos % BYTE_BITS;
    lim    = usable_bytes(shadow_bytes_in_use);
    if (idx >= lim) begin
      rsp.oor = 1'b1;
      n_oor++;
    end else begin
      // two-byte window; past the limit the upper byte reads as zero and is never written
      second_ok = (idx + 1) < lim;
      window[7:0]  = shadow_bytes[idx];
      window[15:8] = 8'h00;
      if (second_ok) window[15:8] = shadow_bytes[idx + 1];
      if (off > LAST_SINGLE_OFFSET) begin
        n_span++;
        if (!second_ok) n_cut++;
      end
      if (req.kind == REQ_WRITE) begin
        mask   = 16'((1 << ENTRY_W) - 1) << off;
        window = (window & ~mask) | (16'(req.val) << off);
        shadow_bytes[idx] = window[7:0];
        if (second_ok) shadow_bytes[idx + 1] = window[15:8];
      end else begin
        rsp.rd = ENTRY_W'(window >> off);
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 100)
      $display("mismatch on %s at result %0d: got %0d, expected %0d", what, n_results, got,
               want);
    err_count++;
  endtask

  task automatic queue_req(input logic [0:0] kind, input int pos, input int val);
    store_req_t r;
    r.kind = kind;
    r.pos  = POS_W'(pos);
    r.val  = ENTRY_W'(val);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_rsps.size() != 0);
  endtask

  task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_bytes_in_use = value;
    n_settings++;
    @(negedge clk);
  endtask

  // driver: bursts of items, sometimes with random gaps between them
  always @(posedge clk) begin : driver
    store_req_t taken;
    store_req_t next_req;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.req_type    <= REQ_READ;
      in_ch.position    <= '0;
      in_ch.write_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken = {in_ch.req_type, in_ch.position, in_ch.write_value};
        expected_rsps.push_back(predict_store_access(taken));
        if (taken.kind == REQ_WRITE) n_writes++;
        else n_reads++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= next_req.kind;
          in_ch.position    <= next_req.pos;
          in_ch.write_value <= next_req.val;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result and drives its own ready pattern
  always @(posedge clk) begin : monitor
    store_rsp_t got;
    store_rsp_t want;
    logic       next_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles  <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.read_value, out_ch.out_of_range};
        n_results++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", int'(got), -1);
        end else begin
          want = expected_rsps.pop_front();
          if (got.rd !== want.rd) report_mismatch("read_value", int'(got.rd), int'(want.rd));
          if (got.oor !== want.oor)
            report_mismatch("out_of_range", int'(got.oor), int'(want.oor));
        end
      end
      idle_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) ?
                     0 : idle_cycles + 1;

      if (pattern_left == 0) begin
        ready_mode   = rdy_mode_t'($urandom_range(0, 2));
        pattern_left = $urandom_range(32, 160);
      end
      pattern_left--;
      case (ready_mode)
        RDY_ALWAYS: next_ready = 1'b1;
        RDY_COIN:   next_ready = 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
          end else if ($urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 20);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
      out_ch.ready <= next_ready;
    end
  end

  initial begin : watchdog
    do @(negedge clk);
    while (idle_cycles < IDLE_LIMIT);
    $display("no handshake for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cfg_plan [$];
    logic [CFG_W-1:0] cfg;
    store_req_t       r;
    int               lim;
    int               top;
    int               sel;
    int               p;

    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    shadow_bytes_in_use = CFG_W'(STORE_BYTES);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset limit
    queue_req(REQ_READ, 0, MAX_VAL);
    queue_req(REQ_WRITE, 0, MAX_VAL);
    queue_req(REQ_READ, 0, 0);
    queue_req(REQ_WRITE, 2, 5);        // starts at bit offset 6
    queue_req(REQ_READ, 2, 0);
    queue_req(REQ_WRITE, 5, 6);        // starts at bit offset 7
    queue_req(REQ_READ, 5, 0);
    queue_req(REQ_READ, 1, 0);
    queue_req(REQ_WRITE, 1, MAX_VAL);
    queue_req(REQ_READ, 0, 0);
    queue_req(REQ_READ, 1, 0);
    queue_req(REQ_READ, 2, 0);
    queue_req(REQ_WRITE, 1365, MAX_VAL); // spans into the byte past the store
    queue_req(REQ_READ, 1365, 0);
    queue_req(REQ_WRITE, 1364, 3);
    queue_req(REQ_READ, 1364, 0);
    queue_req(REQ_WRITE, 1366, MAX_VAL); // first entry past the store
    queue_req(REQ_READ, 1366, 0);
    queue_req(REQ_WRITE, MAX_POS, MAX_VAL);
    queue_req(REQ_READ, MAX_POS, MAX_VAL);
    queue_req(REQ_WRITE, 0, 0);
    queue_req(REQ_READ, 0, 0);
    wait_for_idle();

    cfg_plan = '{10'd0, 10'd1, 10'd1023, 10'd100, 10'd3, 10'd511, 10'd512};
    cfg_plan.push_back(CFG_W'($urandom_range(0, 1023)));
    foreach (cfg_plan[k]) begin
      cfg = cfg_plan[k];
      write_bytes_in_use(cfg);
      lim = usable_bytes(cfg);
      top = last_entry_in(lim);

      // entries around the limit, each written and read back
      for (int d = -1; d <= 1; d++) begin
        p = top + d;
        if (p < 0) p = 0;
        if (p > MAX_POS) p = MAX_POS;
        queue_req(REQ_WRITE, p, $urandom_range(0, MAX_VAL));
        queue_req(REQ_READ, p, $urandom_range(0, MAX_VAL));
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r.kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        r.val  = ENTRY_W'($urandom_range(0, MAX_VAL));
        sel    = $urandom_range(0, 9);
        // mostly in range, a dense low window for read-after-write hits
        if (lim == 0 || sel >= 8) p = $urandom_range(0, MAX_POS);
        else if (sel < 3) p = $urandom_range(0, (top < 40) ? top : 40);
        else if (sel < 6) p = $urandom_range(0, top);
        else p = top + int'($urandom_range(0, 6)) - 3;
        if (p < 0) p = 0;
        if (p > MAX_POS) p = MAX_POS;
        r.pos = POS_W'(p);
        pending_reqs.push_back(r);
      end
      wait_for_idle();
    end

    repeat (8) @(posedge clk);
    $display("ran %0d reads and %0d writes under %0d byte limits, %0d results checked",
             n_reads, n_writes, n_settings, n_results);
    $display("%0d out of range, %0d spanning two bytes, %0d cut at the limit",
             n_oor, n_span, n_cut);
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/pfs_pkg.sv
src/pfs_req_if.sv
src/pfs_rsp_if.sv
src/pfs_decode.sv
src/pfs_store.sv
src/packed_three_bit_field_store.sv
tb/tb_top.sv
